// File: rtl/assert_macros.svh
// assertion macros shared by the profiler rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// clocked property, checking suspended while reset is asserted
`define WTMP_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("profiler assertion failed");
// clocked property, checked through reset as well
`define WTMP_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("profiler assertion failed");
`else
`define WTMP_ASSERT(lbl, clk, rst_n, prop)
`define WTMP_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// File: rtl/wtmp_pkg.sv
// shared widths, constants and controller/datapath interface types
package wtmp_pkg;

    // parameter defaults
    localparam int SLOTS_DEF      = 4;
    localparam int MAX_WINDOW_DEF = 4096;

    // field widths
    localparam int SLOT_W     = 2;
    localparam int HW_SLOTS   = 4;
    localparam int TIME_W     = 32;
    localparam int SUM_W      = 44;
    localparam int FRAME_W    = 32;
    localparam int REC_W      = 20;
    localparam int WARM_W     = 16;
    localparam int MEAS_W     = 20;
    localparam int WINCFG_W   = 13;
    localparam int WINCFG_MAX = 8191;
    localparam int STOP_W     = 21;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MEASURE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW  = 2'd2;

    // configuration reset values
    localparam logic [WARM_W-1:0]   WARM_RST = 16'd0;
    localparam logic [MEAS_W-1:0]   MEAS_RST = 20'd1000;
    localparam logic [WINCFG_W-1:0] WIN_RST  = 13'd60;

    // divider operand select
    typedef enum logic {
        DIV_INDEX = 1'b0,
        DIV_TRIM  = 1'b1
    } t_div_sel;

    // commands from controller to datapath
    typedef struct packed {
        logic     accept;
        logic     div_start;
        t_div_sel div_sel;
        logic     idx_latch;
        logic     out_load;
        logic     out_shift;
        logic     win_finish;
    } t_cmd;

    // status from datapath to controller
    typedef struct packed {
        logic close;
        logic div_done;
        logic last_slot;
    } t_stat;

endpackage

// File: rtl/wtmp_div.sv
// restoring divider, one quotient bit per cycle
`include "assert_macros.svh"
module wtmp_div #(
    parameter int DEN_W = 13
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [wtmp_pkg::SUM_W-1:0] i_num,
    input  logic [DEN_W-1:0]           i_den,
    output logic [wtmp_pkg::SUM_W-1:0] o_quo,
    output logic                       o_done
);
    import wtmp_pkg::*;

    localparam int CNT_W = $clog2(SUM_W);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [SUM_W-1:0] r_quo;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   rem_sh;
    logic [DEN_W:0]   rem_diff;
    logic             ge;
    logic [DEN_W-1:0] n_rem;

    // one trial subtraction
    always_comb begin
        rem_sh   = {r_rem, r_quo[SUM_W-1]};
        rem_diff = rem_sh - {1'b0, r_den};
        ge       = (rem_sh >= {1'b0, r_den});
        n_rem    = ge ? rem_diff[DEN_W-1:0] : rem_sh[DEN_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(SUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // operands, quotient shifts in as dividend shifts out
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
            r_den <= i_den;
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], ge};
            r_rem <= n_rem;
        end
    end

    assign o_quo  = r_quo;
    assign o_done = r_done;

    `WTMP_ASSERT(a_start_busy, i_clk, i_rst_n, i_start |=> r_busy)
    `WTMP_ASSERT(a_done_idle, i_clk, i_rst_n, r_done |-> (!r_busy && $past(r_busy)))

endmodule

// File: rtl/wtmp_dp.sv
// datapath: config registers, per-slot accumulators, division and result registers
module wtmp_dp #(
    parameter int SLOTS      = wtmp_pkg::SLOTS_DEF,
    parameter int MAX_WINDOW = wtmp_pkg::MAX_WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  wtmp_pkg::t_cmd                  i_cmd,
    output wtmp_pkg::t_stat                 o_stat,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wtmp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wtmp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic [wtmp_pkg::SLOT_W-1:0]     i_slot,
    input  logic [wtmp_pkg::TIME_W-1:0]     i_sample_time,
    input  logic                            i_frame_end,
    input  logic                            i_index_present,
    input  logic [wtmp_pkg::TIME_W-1:0]     i_index_value,
    output logic [wtmp_pkg::REC_W-1:0]      o_window_first,
    output logic [wtmp_pkg::SLOT_W-1:0]     o_slot_out,
    output logic [wtmp_pkg::TIME_W-1:0]     o_trimmed_avg,
    output logic                            o_avg_valid,
    output logic [wtmp_pkg::TIME_W-1:0]     o_index_avg,
    output logic                            o_index_valid,
    output logic                            o_last
);
    import wtmp_pkg::*;

    localparam int NSLOT   = (SLOTS < HW_SLOTS) ? SLOTS : HW_SLOTS;
    localparam int WIN_CAP = (MAX_WINDOW < WINCFG_MAX) ? MAX_WINDOW : WINCFG_MAX;
    localparam int FILL_W  = $clog2(WIN_CAP + 1);
    localparam int CMP_W   = WINCFG_W + 1;

    // configuration
    logic [WARM_W-1:0]   r_warm;
    logic [MEAS_W-1:0]   r_meas;
    logic [WINCFG_W-1:0] r_win;

    // run state
    logic [FRAME_W-1:0] r_fc;
    logic [REC_W-1:0]   r_rtot;
    logic [REC_W-1:0]   r_wstart;
    logic [FILL_W-1:0]  r_fill;
    logic [SUM_W-1:0]   r_isum;
    logic               r_iap;
    logic [SUM_W-1:0]   r_sum [NSLOT];
    logic [TIME_W-1:0]  r_min [NSLOT];
    logic [TIME_W-1:0]  r_max [NSLOT];
    logic [SLOT_W-1:0]  r_sidx;
    logic [TIME_W-1:0]  r_iavg;

    // result registers
    logic [REC_W-1:0]  r_out_first;
    logic [SLOT_W-1:0] r_out_slot;
    logic [TIME_W-1:0] r_out_trim;
    logic              r_out_av;
    logic [TIME_W-1:0] r_out_iavg;
    logic              r_out_iv;
    logic              r_out_last;

    logic [STOP_W-1:0]  stop;
    logic               recording;
    logic               at_stop;
    logic [CMP_W-1:0]   win_eff;
    logic [CMP_W-1:0]   fill_inc;
    logic               rec_end;
    logic [SUM_W:0]     isum_add;
    logic [SUM_W-1:0]   isum_sat;
    logic [TIME_W:0]    drop;
    logic [SUM_W-1:0]   trim_num;
    logic [FILL_W-1:0]  trim_den;
    logic               avg_ok;
    logic [SUM_W-1:0]   div_num;
    logic [FILL_W-1:0]  div_den;
    logic [SUM_W-1:0]   quo;
    logic [TIME_W-1:0]  quo_sat;
    logic               div_done;

    // recording window and close decision for the offered item
    always_comb begin
        stop      = STOP_W'(r_warm) + STOP_W'(r_meas);
        recording = (r_fc >= FRAME_W'(r_warm)) &&
                    ({1'b0, r_fc} < (FRAME_W + 1)'(stop));
        at_stop   = (({1'b0, r_fc} + 33'd1) == (FRAME_W + 1)'(stop));
        win_eff   = (r_win == '0) ? CMP_W'(1) : CMP_W'(r_win);
        if (win_eff > CMP_W'(WIN_CAP)) begin
            win_eff = CMP_W'(WIN_CAP);
        end
        fill_inc  = CMP_W'(r_fill) + CMP_W'(1);
        rec_end   = i_frame_end && recording;
        isum_add  = {1'b0, r_isum} + (SUM_W + 1)'(i_index_value);
        isum_sat  = isum_add[SUM_W] ? '1 : isum_add[SUM_W-1:0];
    end

    assign o_stat.close     = rec_end && ((fill_inc >= win_eff) || at_stop);
    assign o_stat.div_done  = div_done;
    assign o_stat.last_slot = (r_sidx == SLOT_W'(NSLOT - 1));

    // configuration writes, index beyond the list ignored
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warm <= WARM_RST;
            r_meas <= MEAS_RST;
            r_win  <= WIN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_WARMUP:  r_warm <= i_cfg_data[WARM_W-1:0];
                CFG_MEASURE: r_meas <= i_cfg_data[MEAS_W-1:0];
                CFG_WINDOW:  r_win  <= i_cfg_data[WINCFG_W-1:0];
                default: ;
            endcase
        end
    end

    // frame counters, window fill and index accumulation
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc     <= '0;
            r_rtot   <= '0;
            r_wstart <= '0;
            r_fill   <= '0;
            r_isum   <= '0;
            r_iap    <= 1'b1;
            r_sidx   <= '0;
        end else begin
            if (i_cmd.accept && i_frame_end && (r_fc != '1)) begin
                r_fc <= r_fc + 1'b1;
            end
            if (i_cmd.accept && rec_end) begin
                r_fill <= fill_inc[FILL_W-1:0];
                r_rtot <= r_rtot + 1'b1;
                if (i_index_present) begin
                    r_isum <= isum_sat;
                end else begin
                    r_iap <= 1'b0;
                end
            end
            if (i_cmd.out_shift) begin
                r_sidx <= r_sidx + 1'b1;
            end
            if (i_cmd.win_finish) begin
                r_wstart <= r_rtot;
                r_fill   <= '0;
                r_isum   <= '0;
                r_sidx   <= '0;
            end
        end
    end

    // per-slot lanes; during results they shift toward lane 0 and refill with reset values
    for (genvar g = 0; g < NSLOT; g++) begin : g_lane
        logic [SUM_W:0]   add;
        logic [SUM_W-1:0] sum_sat;
        logic             hit;

        always_comb begin
            add     = {1'b0, r_sum[g]} + (SUM_W + 1)'(i_sample_time);
            sum_sat = add[SUM_W] ? '1 : add[SUM_W-1:0];
            hit     = i_cmd.accept && recording && (i_slot == SLOT_W'(g));
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sum[g] <= '0;
                r_min[g] <= '1;
                r_max[g] <= '0;
            end else if (i_cmd.out_shift) begin
                if (g == NSLOT - 1) begin
                    r_sum[g] <= '0;
                    r_min[g] <= '1;
                    r_max[g] <= '0;
                end else begin
                    r_sum[g] <= r_sum[(g + 1) % NSLOT];
                    r_min[g] <= r_min[(g + 1) % NSLOT];
                    r_max[g] <= r_max[(g + 1) % NSLOT];
                end
            end else if (hit) begin
                r_sum[g] <= sum_sat;
                if (i_sample_time < r_min[g]) begin
                    r_min[g] <= i_sample_time;
                end
                if (i_sample_time > r_max[g]) begin
                    r_max[g] <= i_sample_time;
                end
            end
        end
    end

    // divider operands: trimmed sum of lane 0 or the index sum
    always_comb begin
        drop     = {1'b0, r_min[0]} + {1'b0, r_max[0]};
        trim_num = (r_sum[0] > SUM_W'(drop)) ? (r_sum[0] - SUM_W'(drop)) : '0;
        trim_den = r_fill - FILL_W'(2);
        avg_ok   = (r_fill > FILL_W'(2));
        div_num  = (i_cmd.div_sel == DIV_TRIM) ? trim_num : r_isum;
        div_den  = (i_cmd.div_sel == DIV_TRIM) ? trim_den : r_fill;
        quo_sat  = (quo[SUM_W-1:TIME_W] != '0) ? '1 : quo[TIME_W-1:0];
    end

    wtmp_div #(
        .DEN_W (FILL_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_quo   (quo),
        .o_done  (div_done)
    );

    // index mean, shared by every slot of the window
    always_ff @(posedge i_clk) begin
        if (i_cmd.idx_latch) begin
            r_iavg <= r_iap ? quo_sat : '0;
        end
    end

    // result item registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_first <= r_wstart;
            r_out_slot  <= r_sidx;
            r_out_trim  <= avg_ok ? quo_sat : '0;
            r_out_av    <= avg_ok;
            r_out_iavg  <= r_iavg;
            r_out_iv    <= r_iap;
            r_out_last  <= (r_sidx == SLOT_W'(NSLOT - 1));
        end
    end

    assign o_window_first = r_out_first;
    assign o_slot_out     = r_out_slot;
    assign o_trimmed_avg  = r_out_trim;
    assign o_avg_valid    = r_out_av;
    assign o_index_avg    = r_out_iavg;
    assign o_index_valid  = r_out_iv;
    assign o_last         = r_out_last;

endmodule

// File: rtl/wtmp_ctrl.sv
// controller: input acceptance and window-close result sequencing
`include "assert_macros.svh"
module wtmp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  wtmp_pkg::t_stat i_stat,
    output wtmp_pkg::t_cmd  o_cmd
);
    import wtmp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_ISTART = 6'b000010,
        S_IWAIT  = 6'b000100,
        S_TSTART = 6'b001000,
        S_TWAIT  = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   out_take;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_OUT);
    assign out_take    = o_out_valid && i_out_ready;

    // commands and next state
    always_comb begin
        o_cmd            = '0;
        o_cmd.div_sel    = DIV_INDEX;
        o_cmd.accept     = i_in_valid && o_in_ready;
        n_state          = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.accept && i_stat.close) begin
                    n_state = S_ISTART;
                end
            end
            S_ISTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_INDEX;
                n_state         = S_IWAIT;
            end
            S_IWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.idx_latch = 1'b1;
                    n_state         = S_TSTART;
                end
            end
            S_TSTART: begin
                o_cmd.div_start = 1'b1;
                o_cmd.div_sel   = DIV_TRIM;
                n_state         = S_TWAIT;
            end
            S_TWAIT: begin
                o_cmd.div_sel = DIV_TRIM;
                if (i_stat.div_done) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_OUT;
                end
            end
            S_OUT: begin
                if (out_take) begin
                    o_cmd.out_shift = 1'b1;
                    if (i_stat.last_slot) begin
                        o_cmd.win_finish = 1'b1;
                        n_state          = S_IDLE;
                    end else begin
                        n_state = S_TSTART;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    `WTMP_ASSERT(a_no_overlap, i_clk, i_rst_n, !(o_in_ready && o_out_valid))
    `WTMP_ASSERT(a_done_waiting, i_clk, i_rst_n, i_stat.div_done |-> (r_state == S_IWAIT || r_state == S_TWAIT))
    `WTMP_ASSERT(a_close_divides, i_clk, i_rst_n, (o_cmd.accept && i_stat.close) |=> (r_state == S_ISTART))
    `WTMP_ASSERT(a_last_idle, i_clk, i_rst_n, (out_take && i_stat.last_slot) |=> o_in_ready)

endmodule

// File: rtl/windowed_trimmed_mean_profiler.sv
// top level of the windowed trimmed-mean frame profiler
// Input channel (i_valid/o_ready) takes one timing sample per item; i_frame_end marks
// the last sample of a frame and qualifies i_index_present and i_index_value.
// Frames numbered from the warmup count up to, but not including, warmup plus measure count are recorded.
// Configuration channel (i_cfg_valid/o_cfg_ready) is always ready; index 0 warmup,
// 1 measure, 2 window size. Write it only while no window is being reported.
// Samples that do not close a window are accepted one per cycle.
// The frame_end item that closes a window starts the report: the index mean takes one
// division, then each slot's trimmed mean takes another; each further slot's division
// starts only after the previous result item is taken. The single shared radix-2
// divider runs these divisions one at a time.
// Input is held off (o_ready low) until the window's last result item,
// flagged by o_last, has been taken.
// Results sit in an output register; if the receiver holds i_ready low the item stays
// on the outputs and the report simply waits.
// Synchronous active-low reset restores the default configuration, clears counters and
// accumulators, and leaves the block ready for input with no result pending.
module windowed_trimmed_mean_profiler #(
    parameter int SLOTS      = wtmp_pkg::SLOTS_DEF,
    parameter int MAX_WINDOW = wtmp_pkg::MAX_WINDOW_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [wtmp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [wtmp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [wtmp_pkg::SLOT_W-1:0]     i_slot,
    input  logic [wtmp_pkg::TIME_W-1:0]     i_sample_time,
    input  logic                            i_frame_end,
    input  logic                            i_index_present,
    input  logic [wtmp_pkg::TIME_W-1:0]     i_index_value,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [wtmp_pkg::REC_W-1:0]      o_window_first,
    output logic [wtmp_pkg::SLOT_W-1:0]     o_slot_out,
    output logic [wtmp_pkg::TIME_W-1:0]     o_trimmed_avg,
    output logic                            o_avg_valid,
    output logic [wtmp_pkg::TIME_W-1:0]     o_index_avg,
    output logic                            o_index_valid,
    output logic                            o_last
);
    import wtmp_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    // sequencing
    wtmp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .o_out_valid (o_valid),
        .i_out_ready (i_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // accumulation and arithmetic
    wtmp_dp #(
        .SLOTS      (SLOTS),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_slot          (i_slot),
        .i_sample_time   (i_sample_time),
        .i_frame_end     (i_frame_end),
        .i_index_present (i_index_present),
        .i_index_value   (i_index_value),
        .o_window_first  (o_window_first),
        .o_slot_out      (o_slot_out),
        .o_trimmed_avg   (o_trimmed_avg),
        .o_avg_valid     (o_avg_valid),
        .o_index_avg     (o_index_avg),
        .o_index_valid   (o_index_valid),
        .o_last          (o_last)
    );

endmodule
